// File: rtl/fnm_pkg.sv
`default_nettype none

package fnm_pkg;

  // match rule reported with each result
  typedef enum logic [2:0] {
    RULE_NONE      = 3'd0,
    RULE_TRANSPOSE = 3'd1,
    RULE_EXTRA     = 3'd2,
    RULE_MISSING   = 3'd3,
    RULE_SUBST     = 3'd4
  } rule_e;

  // shortest second-string lengths for the rules
  localparam int unsigned MinLenShort = 4;
  localparam int unsigned MinLenLong  = 5;

  // result of one string pair
  typedef struct packed {
    logic  matched;
    rule_e rule;
    logic  overflow;
  } fnm_result_t;

endpackage

`default_nettype wire

// File: rtl/fnm_if.sv
`default_nettype none

// input channel: one byte position of both strings per transaction
interface fnm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_one;
  logic [7:0] char_two;
  logic       last;

  modport source (output valid, output char_one, output char_two, output last, input ready);
  modport sink   (input valid, input char_one, input char_two, input last, output ready);
endinterface

// output channel: one match result per string pair
interface fnm_out_if;
  logic       valid;
  logic       ready;
  logic       matched;
  logic [2:0] rule;
  logic       overflow;

  modport source (output valid, output matched, output rule, output overflow, input ready);
  modport sink   (input valid, input matched, input rule, input overflow, output ready);
endinterface

`default_nettype wire

// File: rtl/fnm_core.sv
`default_nettype none

module fnm_core #(
  parameter int unsigned MAX_LEN = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic [7:0]          char_one_i,
  input  wire logic [7:0]          char_two_i,
  input  wire logic                last_i,
  output fnm_pkg::fnm_result_t     result_o
);
  import fnm_pkg::*;

  localparam int unsigned LenW = $clog2(MAX_LEN + 2);
  localparam logic [LenW-1:0] LenMax   = LenW'(MAX_LEN);
  localparam logic [LenW-1:0] LenShort = LenW'(MinLenShort);
  localparam logic [LenW-1:0] LenLong  = LenW'(MinLenLong);

  // shifted compare states
  localparam logic [1:0] SKIP_ALIGNED = 2'd0;
  localparam logic [1:0] SKIP_RUN     = 2'd1;
  localparam logic [1:0] SKIP_FAIL    = 2'd2;

  // transposition states
  localparam logic [1:0] SWAP_EQUAL   = 2'd0;
  localparam logic [1:0] SWAP_PENDING = 2'd1;
  localparam logic [1:0] SWAP_DONE    = 2'd2;
  localparam logic [1:0] SWAP_FAIL    = 2'd3;

  logic [LenW-1:0] len1_q, len1_d, len2_q, len2_d;
  logic [7:0]      prev1_q, prev1_d, prev2_q, prev2_d;
  logic [1:0]      sub_q, sub_d;
  logic [1:0]      extra_q, extra_d, miss_q, miss_d;
  logic [1:0]      swap_q, swap_d;
  logic            eq_pair_q, eq_pair_d;
  logic            ovf_q, ovf_d;
  logic            end1_q, end1_d, end2_q, end2_d;
  logic [7:0]      a, b;
  logic [LenW:0]   len1_x, len2_x;
  logic            swap_ok;
  rule_e           rule;

  function automatic logic [1:0] shift_step(logic [1:0] st, logic aligned_eq,
                                            logic shifted_eq);
    logic [1:0] r;
    r = SKIP_FAIL;
    if (st == SKIP_ALIGNED) r = aligned_eq ? SKIP_ALIGNED : SKIP_RUN;
    else if (st == SKIP_RUN) r = shifted_eq ? SKIP_RUN : SKIP_FAIL;
    return r;
  endfunction

  // bytes past a string end read as zero
  assign a = end1_q ? 8'd0 : char_one_i;
  assign b = end2_q ? 8'd0 : char_two_i;

  // next state for this position
  always_comb begin
    end1_d = end1_q | (a == 8'd0);
    end2_d = end2_q | (b == 8'd0);
    len1_d = len1_q;
    len2_d = len2_q;
    if (a != 8'd0 && len1_q <= LenMax) len1_d = len1_q + 1'b1;
    if (b != 8'd0 && len2_q <= LenMax) len2_d = len2_q + 1'b1;
    ovf_d = ovf_q | (len1_d > LenMax) | (len2_d > LenMax);
    sub_d = sub_q;
    if (a != b && sub_q < 2'd2) sub_d = sub_q + 1'b1;
    eq_pair_d = eq_pair_q | ((b != 8'd0) && (prev2_q == b));
    extra_d = shift_step(extra_q, a == b, a == prev2_q);
    miss_d  = shift_step(miss_q, a == b, prev1_q == b);
    swap_d = swap_q;
    unique case (swap_q)
      SWAP_EQUAL:   if (a != b) swap_d = SWAP_PENDING;
      SWAP_PENDING: swap_d = (a == prev2_q && b == prev1_q) ? SWAP_DONE : SWAP_FAIL;
      SWAP_DONE:    if (a != b) swap_d = SWAP_FAIL;
      default:      swap_d = SWAP_FAIL;
    endcase
    prev1_d = a;
    prev2_d = b;
  end

  // rule selection from the updated state
  assign len1_x  = {1'b0, len1_d};
  assign len2_x  = {1'b0, len2_d};
  assign swap_ok = (len1_d == len2_d) &&
                   (swap_d == SWAP_DONE || (swap_d == SWAP_EQUAL && eq_pair_d));

  always_comb begin
    rule = RULE_NONE;
    if (!ovf_d) begin
      priority if (len2_d >= LenShort && swap_ok) rule = RULE_TRANSPOSE;
      else if (len2_d >= LenShort && len1_x == len2_x + 1'b1 && extra_d != SKIP_FAIL)
        rule = RULE_EXTRA;
      else if (len2_d >= LenLong && len1_x + 1'b1 == len2_x && miss_d != SKIP_FAIL)
        rule = RULE_MISSING;
      else if (len2_d >= LenLong && len1_d == len2_d && sub_d <= 2'd1)
        rule = RULE_SUBST;
      else rule = RULE_NONE;
    end
  end

  assign result_o.matched  = (rule != RULE_NONE);
  assign result_o.rule     = rule;
  assign result_o.overflow = ovf_d;

  // state registers, cleared after each string pair
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len1_q <= '0; len2_q <= '0; prev1_q <= '0; prev2_q <= '0;
      sub_q <= '0; extra_q <= SKIP_ALIGNED; miss_q <= SKIP_ALIGNED;
      swap_q <= SWAP_EQUAL; eq_pair_q <= 1'b0; ovf_q <= 1'b0;
      end1_q <= 1'b0; end2_q <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        len1_q <= '0; len2_q <= '0; prev1_q <= '0; prev2_q <= '0;
        sub_q <= '0; extra_q <= SKIP_ALIGNED; miss_q <= SKIP_ALIGNED;
        swap_q <= SWAP_EQUAL; eq_pair_q <= 1'b0; ovf_q <= 1'b0;
        end1_q <= 1'b0; end2_q <= 1'b0;
      end else begin
        len1_q <= len1_d; len2_q <= len2_d; prev1_q <= prev1_d; prev2_q <= prev2_d;
        sub_q <= sub_d; extra_q <= extra_d; miss_q <= miss_d;
        swap_q <= swap_d; eq_pair_q <= eq_pair_d; ovf_q <= ovf_d;
        end1_q <= end1_d; end2_q <= end2_d;
      end
    end
  end

`ifndef SYNTHESIS
  // the first length never runs past the saturation point
  assert property (@(posedge clk_i) disable iff (!rst_ni) len1_q <= LenMax + 1'b1)
    else $error("first length past saturation");
  // an overflowed pair never reports a rule
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   ovf_d |-> (rule == RULE_NONE))
    else $error("rule reported on overflow");
  // state is clear after a final position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (step_i && last_i) |=> (len1_q == '0 && len2_q == '0 && !ovf_q))
    else $error("state not cleared after last");
`endif

endmodule

`default_nettype wire

// File: rtl/fuzzy_name_match.sv
// result path: the final position passes the input register, then the result register,
// and waits there while the previous result is still held in the result register
// throughput: one byte position per cycle, back to back, set by the input register
// and the single update stage; the output register lets input flow while a result waits,
// up to the next final position, which waits for the result slot
// reset: asynchronous active low, clears all string state and the valid bits of both stages
`default_nettype none

module fuzzy_name_match #(
  parameter int unsigned MAX_LEN = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fnm_in_if.sink    in_i,
  fnm_out_if.source out_o
);
  import fnm_pkg::*;

  logic        in_valid_q;
  logic [7:0]  char_one_q, char_two_q;
  logic        last_q;
  logic        advance;
  logic        out_valid_q, out_valid_d;
  fnm_result_t out_res_q, core_res;

  // the staged position moves on unless it is final and the result slot is held
  assign advance    = in_valid_q && (!last_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      char_one_q <= in_i.char_one;
      char_two_q <= in_i.char_two;
      last_q     <= in_i.last;
    end
  end

  fnm_core #(
    .MAX_LEN(MAX_LEN)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .char_one_i (char_one_q),
    .char_two_i (char_two_q),
    .last_i     (last_q),
    .result_o   (core_res)
  );

  // result register
  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    if (advance && last_q) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && last_q) out_res_q <= core_res;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.matched  = out_res_q.matched;
  assign out_o.rule     = out_res_q.rule;
  assign out_o.overflow = out_res_q.overflow;

`ifndef SYNTHESIS
  // matched flag agrees with the rule code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_q |-> (out_res_q.matched == (out_res_q.rule != RULE_NONE)))
    else $error("matched disagrees with rule");
  // overflow never comes with a match
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && out_res_q.overflow) |-> !out_res_q.matched)
    else $error("match reported with overflow");
  // an empty input stage always takes a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni) !in_valid_q |-> in_i.ready)
    else $error("input stalled while empty");
  // a held result is not dropped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && !out_o.ready) |=> out_valid_q)
    else $error("pending result lost");
`endif

endmodule

`default_nettype wire

// File: tb/tb_top.sv
module tb_top;
  import fnm_pkg::*;

  localparam int unsigned MaxLen    = 64;
  localparam int          LongStall = 80;

  // one byte position of both strings, as driven on the input channel
  typedef struct {
    logic [7:0] c1;
    logic [7:0] c2;
    logic       fin;
  } pos_t;

  typedef logic [7:0] text_t[$];

  // progress of the shifted compares and of the adjacent swap search
  typedef enum logic [1:0] {
    SKEW_ALIGNED = 2'd0,
    SKEW_SHIFTED = 2'd1,
    SKEW_FAILED  = 2'd2
  } skew_e;

  typedef enum logic [2:0] {
    SWAP_EQUAL   = 3'd0,
    SWAP_PENDING = 3'd1,
    SWAP_DONE    = 3'd2,
    SWAP_FAILED  = 3'd3
  } swap_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  fnm_in_if  in_bus ();
  fnm_out_if out_bus ();

  fuzzy_name_match #(
    .MAX_LEN(MaxLen)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  pos_t        pending[$];
  fnm_result_t expected[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_calls   = 0;
  int stall_taken   = 0;
  int stall_left    = 0;
  int errors        = 0;
  int fed_items     = 0;
  int pairs_done    = 0;
  int ovf_pairs     = 0;
  int rule_hits[0:4];

  // predictor state for the string pair in progress
  int unsigned cnt_one, cnt_two;
  logic [7:0]  prior_one, prior_two;
  logic [1:0]  diff_cnt;
  skew_e       ins_st, del_st;
  swap_e       swp_st;
  logic        pair_rep, too_long, end_one, end_two;

  task automatic clear_pair();
    cnt_one   = 0;
    cnt_two   = 0;
    prior_one = 8'h00;
    prior_two = 8'h00;
    diff_cnt  = 2'd0;
    ins_st    = SKEW_ALIGNED;
    del_st    = SKEW_ALIGNED;
    swp_st    = SWAP_EQUAL;
    pair_rep  = 1'b0;
    too_long  = 1'b0;
    end_one   = 1'b0;
    end_two   = 1'b0;
  endtask

  function automatic skew_e skew_next(skew_e st, logic [7:0] a, logic [7:0] b,
                                      logic [7:0] sa, logic [7:0] sb);
    if (st == SKEW_ALIGNED) return (a == b) ? SKEW_ALIGNED : SKEW_SHIFTED;
    if (st == SKEW_SHIFTED) return (sa == sb) ? SKEW_SHIFTED : SKEW_FAILED;
    return SKEW_FAILED;
  endfunction

  // fold one accepted position into the pair state, queue a result on last
  task automatic advance_pair(input logic [7:0] c1_raw, input logic [7:0] c2_raw,
                              input logic fin);
    logic [7:0]  a, b;
    fnm_result_t res;
    logic        swap_ok;
    rule_e       r;
    a = end_one ? 8'h00 : c1_raw;
    b = end_two ? 8'h00 : c2_raw;

    // lengths, saturating one past the limit
    if (a == 8'h00) end_one = 1'b1;
    else if (cnt_one <= MaxLen) cnt_one++;
    if (b == 8'h00) end_two = 1'b1;
    else if (cnt_two <= MaxLen) cnt_two++;
    if (cnt_one > MaxLen || cnt_two > MaxLen) too_long = 1'b1;

    if (a != b && diff_cnt < 2'd2) diff_cnt++;
    if (b != 8'h00 && prior_two == b) pair_rep = 1'b1;

    // first runs ahead for an insertion, second runs ahead for a deletion
    ins_st = skew_next(ins_st, a, b, a, prior_two);
    del_st = skew_next(del_st, a, b, prior_one, b);

    case (swp_st)
      SWAP_EQUAL:   if (a != b) swp_st = SWAP_PENDING;
      SWAP_PENDING: swp_st = (a == prior_two && b == prior_one) ? SWAP_DONE : SWAP_FAILED;
      SWAP_DONE:    if (a != b) swp_st = SWAP_FAILED;
      default: ;
    endcase

    prior_one = a;
    prior_two = b;

    if (fin) begin
      r = RULE_NONE;
      if (!too_long) begin
        swap_ok = (cnt_one == cnt_two) &&
                  (swp_st == SWAP_DONE || (swp_st == SWAP_EQUAL && pair_rep));
        if (cnt_two >= MinLenShort && swap_ok)
          r = RULE_TRANSPOSE;
        else if (cnt_two >= MinLenShort && cnt_one == cnt_two + 1 && ins_st != SKEW_FAILED)
          r = RULE_EXTRA;
        else if (cnt_two >= MinLenLong && cnt_one + 1 == cnt_two && del_st != SKEW_FAILED)
          r = RULE_MISSING;
        else if (cnt_two >= MinLenLong && cnt_one == cnt_two && diff_cnt <= 2'd1)
          r = RULE_SUBST;
      end
      res.matched  = (r != RULE_NONE);
      res.rule     = r;
      res.overflow = too_long;
      expected.push_back(res);
      rule_hits[int'(r)]++;
      pairs_done++;
      if (too_long) ovf_pairs++;
      clear_pair();
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $time);
  endtask

  // input driver: a new transaction only once the previous one has gone
  always @(posedge clk_i or negedge rst_ni) begin : drv_proc
    pos_t nxt;
    if (!rst_ni) begin
      in_bus.valid    <= 1'b0;
      in_bus.char_one <= 8'h00;
      in_bus.char_two <= 8'h00;
      in_bus.last     <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        advance_pair(in_bus.char_one, in_bus.char_two, in_bus.last);
        fed_items++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending.pop_front();
          in_bus.valid    <= 1'b1;
          in_bus.char_one <= nxt.c1;
          in_bus.char_two <= nxt.c2;
          in_bus.last     <= nxt.fin;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver with random back-pressure and the occasional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (stall_calls != stall_taken) begin
        stall_taken = stall_calls;
        stall_left  = LongStall;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin : mon_proc
    fnm_result_t want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      if (expected.size() == 0) begin
        report_mismatch("result with nothing pending, rule", out_bus.rule, -1);
      end else begin
        want = expected.pop_front();
        if (out_bus.matched !== want.matched)
          report_mismatch("matched", out_bus.matched, want.matched);
        if (out_bus.rule !== want.rule)
          report_mismatch("rule", out_bus.rule, want.rule);
        if (out_bus.overflow !== want.overflow)
          report_mismatch("overflow", out_bus.overflow, want.overflow);
      end
    end
  end

  function automatic text_t to_text(string s);
    text_t t;
    int    i;
    for (i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  function automatic logic [7:0] rand_char(bit tiny);
    return tiny ? 8'($urandom_range(97, 99)) : 8'($urandom_range(1, 255));
  endfunction

  // byte of a string at a position: zero right after its end, then zero or junk
  function automatic logic [7:0] char_at(text_t s, int i, bit junk);
    if (i < s.size()) return s[i];
    if (i == s.size()) return 8'h00;
    return junk ? 8'($urandom_range(0, 255)) : 8'h00;
  endfunction

  task automatic queue_pair(input text_t one, input text_t two, input int span,
                            input bit junk);
    pos_t p;
    int   i;
    if (span < 1) span = 1;
    for (i = 0; i < span; i++) begin
      p.c1  = char_at(one, i, junk);
      p.c2  = char_at(two, i, junk);
      p.fin = (i == span - 1);
      pending.push_back(p);
    end
  endtask

  // mostly near misses of a random second string, with some unrelated pairs
  task automatic random_pair();
    text_t      one, two;
    int         n, k, pos, roll, mx, span;
    bit         tiny;
    logic [7:0] tmp;
    tiny = ($urandom_range(0, 2) == 0);
    roll = $urandom_range(0, 99);
    if (roll < 2) n = $urandom_range(MaxLen - 2, MaxLen + 2);
    else if (roll < 12) n = $urandom_range(0, 3);
    else n = $urandom_range(4, 8);
    for (k = 0; k < n; k++) two.push_back(rand_char(tiny));
    one = two;
    case ($urandom_range(0, 7))
      1: if (n >= 2) begin
        pos = $urandom_range(0, n - 2);
        tmp = one[pos];
        one[pos] = one[pos + 1];
        one[pos + 1] = tmp;
      end
      2: one.insert($urandom_range(0, n), rand_char(tiny));
      3: if (n >= 1) one.delete($urandom_range(0, n - 1));
      4: if (n >= 1) one[$urandom_range(0, n - 1)] = rand_char(tiny);
      5: if (n >= 1) begin
        one[$urandom_range(0, n - 1)] = rand_char(tiny);
        one[$urandom_range(0, n - 1)] = rand_char(tiny);
      end
      6: begin
        one.delete();
        k = n + $urandom_range(0, 2) - 1;
        for (pos = 0; pos < k; pos++) one.push_back(rand_char(tiny));
      end
      7: if (n >= 1) begin
        one.delete($urandom_range(0, n - 1));
        one.insert($urandom_range(0, n - 1), rand_char(tiny));
      end
      default: ;
    endcase
    mx = (one.size() > two.size()) ? one.size() : two.size();
    roll = $urandom_range(0, 99);
    if (roll < 65) span = mx + 1;
    else if (roll < 82) span = mx;
    else if (roll < 94) span = mx + $urandom_range(2, 3);
    else span = $urandom_range(1, mx + 1);
    queue_pair(one, two, span, $urandom_range(0, 1));
  endtask

  task automatic random_batch(input int count);
    int target;
    target = pending.size() + count;
    while (pending.size() < target) random_pair();
  endtask

  // sender pause: hold new items back until every result is in
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending.size() != 0 || expected.size() != 0 || in_bus.valid);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    text_t one, two;
    in_bus.valid    = 1'b0;
    in_bus.char_one = 8'h00;
    in_bus.char_two = 8'h00;
    in_bus.last     = 1'b0;
    out_bus.ready   = 1'b0;
    rst_ni          = 1'b0;
    for (int i = 0; i < 5; i++) rule_hits[i] = 0;
    clear_pair();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed pairs: each rule, the length-4 equal-string quirk, extreme bytes
    send_idle_pct = 7;
    recv_idle_pct = 49;
    queue_pair(to_text("aabc"), to_text("aabc"), 4, 1'b0);
    queue_pair(to_text("abcd"), to_text("abcd"), 5, 1'b0);
    one = '{8'h80, 8'h7f, 8'h55, 8'haa, 8'h01};
    two = '{8'h80, 8'h7f, 8'haa, 8'h01};
    queue_pair(one, two, 5, 1'b0);
    queue_pair(to_text("abde"), to_text("abcde"), 5, 1'b0);
    one = '{8'hff, 8'h80, 8'h81, 8'h01, 8'hfe};
    two = '{8'hff, 8'h80, 8'h7f, 8'h01, 8'hfe};
    queue_pair(one, two, 6, 1'b1);
    wait_idle();

    // random pairs, rarely idle sender, busy receiver, one long hold-off
    random_batch(430);
    stall_calls++;
    wait_idle();

    // random pairs, busy sender, rarely idle receiver
    send_idle_pct = 49;
    recv_idle_pct = 7;
    random_batch(430);
    wait_idle();

    // random pairs at full rate, one long hold-off
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_batch(430);
    stall_calls++;
    wait_idle();

    repeat (8) @(posedge clk_i);
    if (expected.size() != 0)
      report_mismatch("results never delivered", 0, expected.size());
    $display("checked %0d byte positions in %0d string pairs, %0d over the length limit",
             fed_items, pairs_done, ovf_pairs);
    $display("rules seen: transpose %0d, extra %0d, missing %0d, substitution %0d, none %0d",
             rule_hits[1], rule_hits[2], rule_hits[3], rule_hits[4], rule_hits[0]);
    if (errors == 0) begin
      $display("fuzzy_name_match regression: pass");
    end else begin
      $display("fuzzy_name_match regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("fuzzy_name_match regression: fail");
    $finish;
  end

endmodule
